FILE: src/bbrq_pkg.sv
// shared types, constants and codes for the broadcast bus receiver queues
package bbrq_pkg;

  localparam int QUEUE_DEPTH = 2048;
  localparam int NUM_UNITS   = 5;

  localparam int WORD_W     = 32;
  localparam int UID_W      = 3;
  localparam int MASK_W     = 5;
  localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int UNIT_W     = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int MASK_UNITS = (NUM_UNITS < MASK_W) ? NUM_UNITS : MASK_W;

  typedef enum logic [1:0] {
    OP_XMIT_CMD  = 2'd0,
    OP_XMIT_DATA = 2'd1,
    OP_POLL      = 2'd2,
    OP_RECV      = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [UID_W-1:0]  unit_id;
    logic [WORD_W-1:0] data_word;
  } item_t;

  typedef struct packed {
    logic              xmit_ok;
    logic              word_available;
    logic [WORD_W-1:0] read_word;
    logic [MASK_W-1:0] drop_mask;
    logic              bad_unit;
  } result_t;

  // per-queue request from the bus controller
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [WORD_W-1:0] word;
  } q_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } q_status_t;

endpackage

FILE: src/broadcast_bus_receiver_queues_core.sv
// top level: bus controller, per-receiver queues and result register
// Five units share a broadcast bus; each owns a ring fifo of 2048 32-bit words held in its
// own ram bank, so a transmit writes the bank of every other non-full unit in the same
// cycle. One item is handled at a time: a transmit, poll, bad unit or empty receive loads
// the result register from the execute state, a receive that pops a word from the read
// state that follows it because of the registered read of the bank; both wait while the
// previous result still waits for the sink. The next item is accepted the cycle after the
// result is loaded, while that result may still wait for the sink. A full receiver drops
// the word, is flagged in drop_mask and counts the drop in a saturating counter. No
// clearing pass is needed after reset; fifo words are only read after being written.
module broadcast_bus_receiver_queues_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bbrq_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bbrq_pkg::result_t result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t                          state, state_next;
  bbrq_pkg::item_t                 req;
  bbrq_pkg::result_t               result_next;
  logic                            load_result;
  logic                            slot_free, fire, is_xmit, bad;
  logic [bbrq_pkg::UID_W-1:0]      unit_m1;
  logic [bbrq_pkg::UNIT_W-1:0]     sel;
  logic [bbrq_pkg::MASK_W-1:0]     mask;
  logic [bbrq_pkg::NUM_UNITS-1:0]  push_vec, pop_vec;

  bbrq_pkg::q_cmd_t                q_cmd    [bbrq_pkg::NUM_UNITS];
  bbrq_pkg::q_status_t             q_status [bbrq_pkg::NUM_UNITS];
  logic [bbrq_pkg::WORD_W-1:0]     q_rdata  [bbrq_pkg::NUM_UNITS];

  assign item_stall = (state != S_IDLE);
  assign slot_free  = !result_valid || !result_stall;

  assign is_xmit = (req.op == bbrq_pkg::OP_XMIT_CMD) || (req.op == bbrq_pkg::OP_XMIT_DATA);
  assign bad     = (req.unit_id == '0) ||
                   ({1'b0, req.unit_id} > (bbrq_pkg::UID_W + 1)'(bbrq_pkg::NUM_UNITS));
  assign unit_m1 = req.unit_id - bbrq_pkg::UID_W'(1);
  assign sel     = unit_m1[bbrq_pkg::UNIT_W-1:0];
  assign fire    = (state == S_EXEC) && slot_free && !bad;

  always_comb begin
    mask = '0;
    for (int u = 0; u < bbrq_pkg::MASK_UNITS; u++) begin
      if (is_xmit && req.unit_id != bbrq_pkg::UID_W'(u + 1) && q_status[u].full) begin
        mask[u] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int u = 0; u < bbrq_pkg::NUM_UNITS; u++) begin
      // sender never receives its own word
      push_vec[u] = fire && is_xmit && req.unit_id != bbrq_pkg::UID_W'(u + 1);
      pop_vec[u]  = fire && req.op == bbrq_pkg::OP_RECV &&
                    sel == bbrq_pkg::UNIT_W'(u) && q_status[u].nonempty;
      q_cmd[u].push = push_vec[u];
      q_cmd[u].pop  = pop_vec[u];
      q_cmd[u].word = req.data_word;
    end
  end

  for (genvar g = 0; g < bbrq_pkg::NUM_UNITS; g++) begin : g_queue
    bbrq_queue u_queue (
      .clk     (clk),
      .rst     (rst),
      .cmd     (q_cmd[g]),
      .status  (q_status[g]),
      .rd_data (q_rdata[g])
    );
  end

  always_comb begin
    state_next  = state;
    load_result = 1'b0;
    result_next = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          if (bad) begin
            result_next.bad_unit = 1'b1;
            load_result          = 1'b1;
            state_next           = S_IDLE;
          end else if (|pop_vec) begin
            state_next = S_READ;
          end else begin
            result_next.xmit_ok        = is_xmit;
            result_next.word_available = !is_xmit && q_status[sel].nonempty;
            result_next.drop_mask      = mask;
            load_result                = 1'b1;
            state_next                 = S_IDLE;
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          result_next.word_available = 1'b1;
          result_next.read_word      = q_rdata[sel];
          load_result                = 1'b1;
          state_next                 = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      req <= item;
    end
    if (load_result) begin
      result <= result_next;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == S_EXEC)
    else $error("accepted transaction did not enter execution");

  a_single_pop: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pop_vec) && !(|pop_vec && |push_vec))
    else $error("more than one queue popped or pop mixed with push");

  a_read_after_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> $past(state) == S_EXEC && $past(|pop_vec))
    else $error("read state entered without a pop");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_unit |-> !result.xmit_ok && !result.word_available &&
      result.read_word == '0 && result.drop_mask == '0)
    else $error("bad unit result carries other fields");

  a_mask_xmit: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.xmit_ok |-> result.drop_mask == '0)
    else $error("drop mask set on a non-transmit result");

endmodule

FILE: src/bbrq_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bbrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/bbrq_queue.sv
// one receiver's ring fifo: head, fill and drop counter around a word ram
module bbrq_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  bbrq_pkg::q_cmd_t           cmd,
  output bbrq_pkg::q_status_t        status,
  output logic [bbrq_pkg::WORD_W-1:0] rd_data
);

  localparam int SUM_W = bbrq_pkg::FILL_W + 1;

  logic [bbrq_pkg::PTR_W-1:0]  head, head_next;
  logic [bbrq_pkg::FILL_W-1:0] fill, fill_next;
  logic [31:0]                 drops, drops_next;
  logic [SUM_W-1:0]            tail_sum, tail_wrap;
  logic                        full, nonempty, do_write, do_read;

  assign full     = (fill == bbrq_pkg::FILL_W'(bbrq_pkg::QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign do_write = cmd.push && !full;
  assign do_read  = cmd.pop && nonempty;

  assign status.nonempty = nonempty;
  assign status.full     = full;

  // tail = (head + fill) mod depth, sum is below twice the depth
  assign tail_sum  = SUM_W'(head) + SUM_W'(fill);
  assign tail_wrap = (tail_sum >= SUM_W'(bbrq_pkg::QUEUE_DEPTH)) ?
                     tail_sum - SUM_W'(bbrq_pkg::QUEUE_DEPTH) : tail_sum;

  always_comb begin
    head_next  = head;
    fill_next  = fill;
    drops_next = drops;
    if (do_read) begin
      head_next = (head == bbrq_pkg::PTR_W'(bbrq_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  head + bbrq_pkg::PTR_W'(1);
      fill_next = fill - bbrq_pkg::FILL_W'(1);
    end else if (do_write) begin
      fill_next = fill + bbrq_pkg::FILL_W'(1);
    end else if (cmd.push && drops != 32'hFFFF_FFFF) begin
      // full receiver drops the word, counter saturates
      drops_next = drops + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fill  <= '0;
      drops <= '0;
    end else begin
      head  <= head_next;
      fill  <= fill_next;
      drops <= drops_next;
    end
  end

  bbrq_ram #(
    .WIDTH (bbrq_pkg::WORD_W),
    .DEPTH (bbrq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (tail_wrap[bbrq_pkg::PTR_W-1:0]),
    .wr_data (cmd.word),
    .rd_en   (do_read),
    .rd_addr (head),
    .rd_data (rd_data)
  );

endmodule
